// File: design/oriented_box_wireframe_generator_macros.svh
// assertion helpers used by the top design file
`ifndef ORIENTED_BOX_WIREFRAME_GENERATOR_MACROS_SVH
`define ORIENTED_BOX_WIREFRAME_GENERATOR_MACROS_SVH

// same-cycle implication under reset
`define OBWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obwg assertion failed");

// next-cycle implication under reset
`define OBWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obwg assertion failed");

`endif

// File: design/obwg_pkg.sv
`timescale 1ns / 1ps
package obwg_pkg;

  localparam int COORD_BITS   = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int TRIG_BITS    = 32;
  localparam int TRIG_FRAC    = 30;
  localparam int PROD_BITS    = COORD_BITS + TRIG_BITS;
  localparam int CORDIC_STEPS = 30;
  localparam int VERT_COUNT   = 24;
  localparam int NUM_BITS     = 5;
  localparam logic signed [TRIG_BITS-1:0] CORDIC_K = 32'sd652032874;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TRIG_BITS-1:0]  trig_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic [ANGLE_BITS-1:0]        angle_t;
  typedef logic [NUM_BITS-1:0]          vnum_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t hx;
    coord_t hy;
    coord_t hz;
  } box_t;

  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // corner index for each line-list position
  function automatic logic [2:0] edge_corner(input vnum_t n);
    logic [2:0] c;
    unique case (n)
      5'd0: c = 3'd0;  5'd1: c = 3'd1;  5'd2: c = 3'd1;  5'd3: c = 3'd2;
      5'd4: c = 3'd2;  5'd5: c = 3'd3;  5'd6: c = 3'd3;  5'd7: c = 3'd0;
      5'd8: c = 3'd4;  5'd9: c = 3'd5;  5'd10: c = 3'd5; 5'd11: c = 3'd6;
      5'd12: c = 3'd6; 5'd13: c = 3'd7; 5'd14: c = 3'd7; 5'd15: c = 3'd4;
      5'd16: c = 3'd0; 5'd17: c = 3'd4; 5'd18: c = 3'd1; 5'd19: c = 3'd5;
      5'd20: c = 3'd2; 5'd21: c = 3'd6; 5'd22: c = 3'd3; 5'd23: c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic prod_t mul(input coord_t a, input trig_t t);
    return prod_t'(a) * prod_t'(t);
  endfunction

  // round half up, drop the fraction, keep the low coordinate bits
  function automatic coord_t rnd(input prod_t p);
    prod_t s;
    s = (p + (prod_t'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    return s[COORD_BITS-1:0];
  endfunction

endpackage

// File: design/obwg_box_if.sv
`timescale 1ns / 1ps
interface obwg_box_if import obwg_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t center_x;
  coord_t center_y;
  coord_t center_z;
  coord_t half_x;
  coord_t half_y;
  coord_t half_z;
  angle_t angle_x;
  angle_t angle_y;
  angle_t angle_z;

  modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
                  angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
                angle_x, angle_y, angle_z, output ready);
endinterface

// File: design/obwg_vert_if.sv
`timescale 1ns / 1ps
interface obwg_vert_if import obwg_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t vertex_z;
  vnum_t  vertex_number;
  logic   last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_number, last_vertex,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, vertex_number, last_vertex,
                output ready);
endinterface

// File: design/obwg_sincos.sv
`timescale 1ns / 1ps
module obwg_sincos import obwg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  box_t   box_i,
  input  angle_t ang_i [3],
  output logic   valid_o,
  output box_t   box_o,
  output trig_t  cos_o [3],
  output trig_t  sin_o [3]
);

  localparam int NS = CORDIC_STEPS + 1;

  logic        v_q   [NS];
  box_t        box_q [NS];
  trig_t       x_q   [3][NS];
  trig_t       y_q   [3][NS];
  logic [31:0] z_q   [3][NS];
  logic        neg_q [3][NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < NS; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      box_q[0] <= box_i;
      for (int s = 1; s < NS; s++) box_q[s] <= box_q[s-1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [31:0] z0;
    logic        q_swap;
    assign z0     = {ang_i[l], {(32-ANGLE_BITS){1'b0}}};
    // second and third quadrants: fold by a half turn, negate later
    assign q_swap = z0[31] ^ z0[30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[l][0]   <= CORDIC_K;
        y_q[l][0]   <= '0;
        z_q[l][0]   <= {z0[31] ^ q_swap, z0[30:0]};
        neg_q[l][0] <= q_swap;
      end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          neg_q[l][s+1] <= neg_q[l][s];
          if (!z_q[l][s][31]) begin
            x_q[l][s+1] <= x_q[l][s] - (y_q[l][s] >>> s);
            y_q[l][s+1] <= y_q[l][s] + (x_q[l][s] >>> s);
            z_q[l][s+1] <= z_q[l][s] - atan_at(5'(s));
          end else begin
            x_q[l][s+1] <= x_q[l][s] + (y_q[l][s] >>> s);
            y_q[l][s+1] <= y_q[l][s] - (x_q[l][s] >>> s);
            z_q[l][s+1] <= z_q[l][s] + atan_at(5'(s));
          end
        end
      end
    end

    assign cos_o[l] = neg_q[l][NS-1] ? -x_q[l][NS-1] : x_q[l][NS-1];
    assign sin_o[l] = neg_q[l][NS-1] ? -y_q[l][NS-1] : y_q[l][NS-1];
  end

  assign valid_o = v_q[NS-1];
  assign box_o   = box_q[NS-1];

endmodule

// File: design/oriented_box_wireframe_generator.sv
`timescale 1ns / 1ps
// channel  | dir | moves
// box_i    | in  | one box: centre, half extents, three angles
// vert_o   | out | one line-list vertex, 24 per box
//
// a box is loaded into the vertex sequencer when it is idle or in the same cycle that it issues
// the last vertex of the previous box; it issues one vertex a cycle while vert_o is not stalled.
// each box passes the sine/cosine pipeline, the sequencer load register and 8 vertex stages.
// up to 31 boxes queue in the sine/cosine pipeline while the sequencer is busy.
// reset clears only valid bits and the sequencer. a stall on vert_o freezes the vertex
// stages and, once the sequencer is full, the sine/cosine pipeline; nothing is lost.
module oriented_box_wireframe_generator import obwg_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  obwg_box_if.sink  box_i,
  obwg_vert_if.source vert_o
);
`include "oriented_box_wireframe_generator_macros.svh"

  localparam int VSTAGES = 8;

  typedef struct packed {
    coord_t x, y, z;
    coord_t cx, cy, cz;
    trig_t  cax, cay, caz;
    trig_t  sax, say, saz;
    vnum_t  num;
    logic   last;
  } vtx_t;

  // sine/cosine front end
  logic   en_s, sc_valid, load;
  box_t   box_in, sc_box;
  angle_t ang_in [3];
  trig_t  sc_cos [3], sc_sin [3];

  assign box_in = '{cx: box_i.center_x, cy: box_i.center_y, cz: box_i.center_z,
                    hx: box_i.half_x, hy: box_i.half_y, hz: box_i.half_z};
  assign ang_in[0] = box_i.angle_x;
  assign ang_in[1] = box_i.angle_y;
  assign ang_in[2] = box_i.angle_z;

  assign en_s        = !sc_valid || load;
  assign box_i.ready = en_s;

  obwg_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_s),
    .valid_i (box_i.valid),
    .box_i   (box_in),
    .ang_i   (ang_in),
    .valid_o (sc_valid),
    .box_o   (sc_box),
    .cos_o   (sc_cos),
    .sin_o   (sc_sin)
  );

  // vertex sequencer
  logic   busy_q, issue, en_v;
  vnum_t  cnt_q;
  box_t   seq_box_q;
  trig_t  seq_cos_q [3], seq_sin_q [3];

  assign issue = busy_q && en_v;
  assign load  = sc_valid && (!busy_q || (issue && cnt_q == vnum_t'(VERT_COUNT-1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (issue) begin
      if (cnt_q == vnum_t'(VERT_COUNT-1)) busy_q <= 1'b0;
      else cnt_q <= cnt_q + vnum_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seq_box_q <= sc_box;
      seq_cos_q <= sc_cos;
      seq_sin_q <= sc_sin;
    end
  end

  logic [2:0] corner;
  vtx_t       issue_d;
  assign corner = edge_corner(cnt_q);

  always_comb begin
    issue_d      = '0;
    issue_d.x    = (corner[0] ^ corner[1]) ? seq_box_q.hx : -seq_box_q.hx;
    issue_d.y    = corner[1] ? seq_box_q.hy : -seq_box_q.hy;
    issue_d.z    = corner[2] ? seq_box_q.hz : -seq_box_q.hz;
    issue_d.cx   = seq_box_q.cx;
    issue_d.cy   = seq_box_q.cy;
    issue_d.cz   = seq_box_q.cz;
    issue_d.cax  = seq_cos_q[0];
    issue_d.cay  = seq_cos_q[1];
    issue_d.caz  = seq_cos_q[2];
    issue_d.sax  = seq_sin_q[0];
    issue_d.say  = seq_sin_q[1];
    issue_d.saz  = seq_sin_q[2];
    issue_d.num  = cnt_q;
    issue_d.last = (cnt_q == vnum_t'(VERT_COUNT-1));
  end

  // vertex pipeline: products and sums alternate for each axis rotation
  logic  val_q [VSTAGES];
  vtx_t  v_q   [VSTAGES];
  prod_t p1_q [4], p3_q [4], p5_q [4];
  vtx_t  s2_d, s4_d, s6_d, s7_d;

  assign en_v = !val_q[VSTAGES-1] || vert_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < VSTAGES; s++) val_q[s] <= 1'b0;
    end else if (en_v) begin
      val_q[0] <= busy_q;
      for (int s = 1; s < VSTAGES; s++) val_q[s] <= val_q[s-1];
    end
  end

  always_comb begin
    s2_d   = v_q[1];
    s2_d.y = rnd(p1_q[0]) + rnd(p1_q[1]);
    s2_d.z = rnd(p1_q[2]) + rnd(p1_q[3]);
    s4_d   = v_q[3];
    s4_d.x = rnd(p3_q[0]) + rnd(p3_q[1]);
    s4_d.z = rnd(p3_q[2]) + rnd(p3_q[3]);
    s6_d   = v_q[5];
    s6_d.x = rnd(p5_q[0]) + rnd(p5_q[1]);
    s6_d.y = rnd(p5_q[2]) + rnd(p5_q[3]);
    s7_d   = v_q[6];
    s7_d.x = v_q[6].x + v_q[6].cx;
    s7_d.y = v_q[6].y + v_q[6].cy;
    s7_d.z = v_q[6].z + v_q[6].cz;
  end

  always_ff @(posedge clk_i) begin
    if (en_v) begin
      v_q[0] <= issue_d;
      // about x
      v_q[1]  <= v_q[0];
      p1_q[0] <= mul(v_q[0].y, v_q[0].cax);
      p1_q[1] <= mul(v_q[0].z, -v_q[0].sax);
      p1_q[2] <= mul(v_q[0].y, v_q[0].sax);
      p1_q[3] <= mul(v_q[0].z, v_q[0].cax);
      v_q[2]  <= s2_d;
      // about y
      v_q[3]  <= v_q[2];
      p3_q[0] <= mul(v_q[2].x, v_q[2].cay);
      p3_q[1] <= mul(v_q[2].z, v_q[2].say);
      p3_q[2] <= mul(v_q[2].z, v_q[2].cay);
      p3_q[3] <= mul(v_q[2].x, -v_q[2].say);
      v_q[4]  <= s4_d;
      // about z
      v_q[5]  <= v_q[4];
      p5_q[0] <= mul(v_q[4].x, v_q[4].caz);
      p5_q[1] <= mul(v_q[4].y, -v_q[4].saz);
      p5_q[2] <= mul(v_q[4].x, v_q[4].saz);
      p5_q[3] <= mul(v_q[4].y, v_q[4].caz);
      v_q[6]  <= s6_d;
      // centre offset, output register
      v_q[7]  <= s7_d;
    end
  end

  assign vert_o.valid         = val_q[VSTAGES-1];
  assign vert_o.vertex_x      = v_q[VSTAGES-1].x;
  assign vert_o.vertex_y      = v_q[VSTAGES-1].y;
  assign vert_o.vertex_z      = v_q[VSTAGES-1].z;
  assign vert_o.vertex_number = v_q[VSTAGES-1].num;
  assign vert_o.last_vertex   = v_q[VSTAGES-1].last;

  `OBWG_ASSERT_IMP(a_last_is_final, clk_i, rst_ni, vert_o.valid && vert_o.last_vertex, vert_o.vertex_number == vnum_t'(VERT_COUNT-1))
  `OBWG_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, busy_q, cnt_q < vnum_t'(VERT_COUNT))
  `OBWG_ASSERT_NXT(a_pipe_reaches_out, clk_i, rst_ni, en_v && val_q[VSTAGES-2], vert_o.valid)

endmodule

// File: tb/tb_box_if.sv
`timescale 1ns / 1ps
// the design interfaces are used directly; this file holds the box and vertex item types for the testbench
package tb_box_pkg;
  import obwg_pkg::*;

  typedef struct {
    coord_t cen [3];
    coord_t half [3];
    angle_t ang [3];
  } box_item_t;

  typedef struct {
    coord_t vx;
    coord_t vy;
    coord_t vz;
    vnum_t  num;
    logic   last;
  } vert_item_t;
endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import obwg_pkg::*;
  import tb_box_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   cycle_cnt;
  int   fail_cnt;
  int   stall_left;
  bit   calm;
  bit   stim_done;
  bit   box_acc_q;

  box_item_t  box_queue [$];
  vert_item_t vert_expect [$];

  obwg_box_if  box_if ();
  obwg_vert_if vert_if ();

  oriented_box_wireframe_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_if.sink),
    .vert_o (vert_if.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // round half up, 128-bit so nothing overflows
  function automatic longint mul_q30(longint a, longint t);
    logic signed [127:0] p;
    p = 128'(a) * 128'(t) + (128'sd1 <<< 29);
    return longint'(p >>> 30);
  endfunction

  function automatic void sin_cos(angle_t a, output longint c, output longint s);
    logic [31:0]    z;
    longint         x;
    longint         y;
    longint         xn;
    bit             neg;
    logic [31:0]    atn [30];
    atn = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    z = {a, 16'h0};
    neg = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
    if (neg) z = z + 32'h80000000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (!z[31]) begin
        xn = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atn[i];
      end else begin
        xn = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atn[i];
      end
      x = xn;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic coord_t lin_comb(coord_t a, longint p, coord_t b, longint q);
    return coord_t'(mul_q30(longint'(a), p) + mul_q30(longint'(b), q));
  endfunction

  function automatic void predict_wireframe(box_item_t b);
    longint     cs [3];
    longint     sn [3];
    coord_t     wx [8];
    coord_t     wy [8];
    coord_t     wz [8];
    coord_t     x, y, z, t1, t2;
    int         ring [24];
    vert_item_t v;
    ring = '{0, 1, 1, 2, 2, 3, 3, 0, 4, 5, 5, 6, 6, 7, 7, 4, 0, 4, 1, 5, 2, 6, 3, 7};
    for (int j = 0; j < 3; j++) sin_cos(b.ang[j], cs[j], sn[j]);
    for (int k = 0; k < 8; k++) begin
      x = (k[0] ^ k[1]) ? b.half[0] : -b.half[0];
      y = k[1] ? b.half[1] : -b.half[1];
      z = k[2] ? b.half[2] : -b.half[2];
      t1 = lin_comb(y, cs[0], z, -sn[0]);
      t2 = lin_comb(y, sn[0], z, cs[0]);
      y = t1; z = t2;
      t1 = lin_comb(x, cs[1], z, sn[1]);
      t2 = lin_comb(z, cs[1], x, -sn[1]);
      x = t1; z = t2;
      t1 = lin_comb(x, cs[2], y, -sn[2]);
      t2 = lin_comb(x, sn[2], y, cs[2]);
      x = t1; y = t2;
      wx[k] = x + b.cen[0];
      wy[k] = y + b.cen[1];
      wz[k] = z + b.cen[2];
    end
    for (int n = 0; n < 24; n++) begin
      v.vx = wx[ring[n]];
      v.vy = wy[ring[n]];
      v.vz = wz[ring[n]];
      v.num = vnum_t'(n);
      v.last = (n == 23);
      vert_expect.push_back(v);
    end
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(32'h80000000);
      1: return coord_t'(32'h7FFFFFFF);
      2: return coord_t'($urandom_range(0, 32'h7FFFF)) - coord_t'(32'h40000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 4))
      0: return angle_t'($urandom_range(0, 3) * 16384);
      1: return angle_t'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
      default: return angle_t'($urandom);
    endcase
  endfunction

  // box item taken at this rising edge
  always @(posedge clk_i) begin
    box_acc_q <= rst_ni && box_if.valid && box_if.ready;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_if.valid <= 1'b0;
    end else begin
      if (box_acc_q) begin
        predict_wireframe(box_queue.pop_front());
      end
      if (box_if.valid && !box_acc_q) begin
        // item still waiting: hold it
        box_if.valid <= 1'b1;
      end else if (box_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 27)) begin
        box_if.valid    <= 1'b1;
        box_if.center_x <= box_queue[0].cen[0];
        box_if.center_y <= box_queue[0].cen[1];
        box_if.center_z <= box_queue[0].cen[2];
        box_if.half_x   <= box_queue[0].half[0];
        box_if.half_y   <= box_queue[0].half[1];
        box_if.half_z   <= box_queue[0].half[2];
        box_if.angle_x  <= box_queue[0].ang[0];
        box_if.angle_y  <= box_queue[0].ang[1];
        box_if.angle_z  <= box_queue[0].ang[2];
      end else begin
        box_if.valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      vert_if.ready <= 1'b0;
    end else begin
      vert_if.ready <= calm || $urandom_range(0, 99) >= 27;
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk_i) begin
    vert_item_t e;
    if (rst_ni && vert_if.valid && vert_if.ready) begin
      if (vert_expect.size() == 0) begin
        $error("unexpected vertex item %0d", vert_if.vertex_number);
        fail_cnt++;
      end else begin
        e = vert_expect.pop_front();
        if (vert_if.vertex_x !== e.vx) begin
          $error("vertex_x exp %h got %h", e.vx, vert_if.vertex_x);
          fail_cnt++;
        end
        if (vert_if.vertex_y !== e.vy) begin
          $error("vertex_y exp %h got %h", e.vy, vert_if.vertex_y);
          fail_cnt++;
        end
        if (vert_if.vertex_z !== e.vz) begin
          $error("vertex_z exp %h got %h", e.vz, vert_if.vertex_z);
          fail_cnt++;
        end
        if (vert_if.vertex_number !== e.num) begin
          $error("vertex_number exp %0d got %0d", e.num, vert_if.vertex_number);
          fail_cnt++;
        end
        if (vert_if.last_vertex !== e.last) begin
          $error("last_vertex exp %0d got %0d", e.last, vert_if.last_vertex);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("oriented_box_wireframe_generator: mismatch");
      $finish;
    end
  end

  initial begin
    box_item_t b;
    int        tail;
    rst_ni = 1'b0;
    cycle_cnt = 0;
    fail_cnt = 0;
    stall_left = 0;
    calm = 1'b0;
    stim_done = 1'b0;
    box_if.valid = 1'b0;
    box_if.center_x = '0;
    box_if.center_y = '0;
    box_if.center_z = '0;
    box_if.half_x = '0;
    box_if.half_y = '0;
    box_if.half_z = '0;
    box_if.angle_x = '0;
    box_if.angle_y = '0;
    box_if.angle_z = '0;
    vert_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: axis-aligned, quadrant edges, extreme extents and centres
    for (int d = 0; d < 20; d++) begin
      for (int j = 0; j < 3; j++) begin
        b.cen[j] = (d < 4) ? coord_t'(0) : rand_coord();
        b.half[j] = coord_t'(32'h10000 * (j + 1));
        b.ang[j] = '0;
      end
      case (d)
        1: b.ang = '{16'h4000, 16'h0, 16'h0};
        2: b.ang = '{16'h0, 16'h8000, 16'h0};
        3: b.ang = '{16'h0, 16'h0, 16'hC000};
        4: b.half = '{coord_t'(32'h80000000), coord_t'(32'h80000000), coord_t'(32'h80000000)};
        5: b.half = '{coord_t'(32'h7FFFFFFF), coord_t'(32'h7FFFFFFF), coord_t'(32'h7FFFFFFF)};
        6: b.ang = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        7: b.ang = '{16'h3FFF, 16'h7FFF, 16'hBFFF};
        8: b.ang = '{16'h4001, 16'h8001, 16'hC001};
        9: b.cen = '{coord_t'(32'h7FFFFFFF), coord_t'(32'h80000000), coord_t'(32'hFFFFFFFF)};
        10: b.half = '{coord_t'(0), coord_t'(0), coord_t'(0)};
        default: begin
          for (int j = 0; j < 3; j++) begin
            b.half[j] = rand_coord();
            b.ang[j] = rand_angle();
          end
        end
      endcase
      box_queue.push_back(b);
    end
    for (int r = 0; r < 230; r++) begin
      for (int j = 0; j < 3; j++) begin
        b.cen[j] = rand_coord();
        b.half[j] = rand_coord();
        b.ang[j] = rand_angle();
      end
      box_queue.push_back(b);
    end

    // long receiver hold-off while the sender keeps offering
    wait (box_queue.size() < 200);
    @(negedge clk_i);
    stall_left <= 1500;
    wait (box_queue.size() < 120);
    calm = 1'b1;
    wait (box_queue.size() < 80);
    calm = 1'b0;
    wait (box_queue.size() == 0);
    wait (vert_expect.size() == 0);
    tail = 0;
    while (tail < 60) begin
      @(posedge clk_i);
      tail++;
    end
    if (fail_cnt == 0 && vert_expect.size() == 0) begin
      $display("oriented_box_wireframe_generator: match");
    end else begin
      $display("oriented_box_wireframe_generator: mismatch");
    end
    $finish;
  end
endmodule
